FILE: src/oms_pkg.sv
// Shared constants, register codes and helper functions of the odometry motion sampler.
package oms_pkg;

  localparam int          CFG_IDX_W       = 3;
  localparam int          ATAN_ENTRIES    = 24;
  localparam logic [29:0] INVK_Q30        = 30'd652032875;
  localparam logic [30:0] INV_PI_Q32      = 31'd1367130551;
  localparam logic [17:0] PI_SQ_Q14       = 18'd161704;
  localparam logic [6:0]  TRANS_GUARD_Q16 = 7'd66;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PREV_HEAD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_HEAD   = 3'd7;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] alpha_sat(input logic [127:0] p);
    return (p[127:80] != '0) ? {64{1'b1}} : p[79:16];
  endfunction

endpackage

FILE: src/odometry_motion_sample.sv
// Odometry motion model sampler: moves one particle pose per beat by a noisy odometry step.
//
//  port group | dir | payload
//  in_        | in  | particle x, y, heading and three noise samples
//  out_       | out | moved x, y and heading
//  cfg_       | in  | register index and data
//
// One particle is accepted every cycle while the serial unit is idle and the skid stage is empty.
// After reset and after every register write a serial unit (shared shift-add multiplier,
// bit-pair square root, one CORDIC step per cycle) rebuilds the motion terms and sigmas,
// and in_tready stays low until it has finished.
// The pipeline stalls as a whole only when the output register and its skid stage are full.
module odometry_motion_sample #(
  parameter int POS_WIDTH     = 32,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int IN_BITS  = 2 * POS_WIDTH + ANGLE_WIDTH + 48,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * POS_WIDTH + ANGLE_WIDTH,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // particle_x, particle_y, particle_heading, noise_first_turn, noise_travel,
  // noise_second_turn
  input  logic [IN_W-1:0]                in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // moved_x, moved_y, moved_heading
  output logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [POS_WIDTH-1:0]           cfg_data
);
  import oms_pkg::*;

  localparam int PW   = POS_WIDTH;
  localparam int AW   = ANGLE_WIDTH;
  localparam int NS   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int XW   = PW + 10;
  localparam int TW   = PW + 1;
  localparam int TRW  = PW + 16;
  localparam int TMW  = TRW - 1;
  localparam int CW   = 33;
  localparam int ZW   = 34;
  localparam int RS   = 61 - AW;
  localparam int SQS  = 2 * AW - 20;
  localparam int MW   = TMW + 3;
  localparam int SW   = MW + 2;
  localparam int THW  = TMW - 32;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CINIT = 3'd1;
  localparam logic [2:0] ST_CROT  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;

  localparam logic [3:0] OP_TRANS = 4'd0;
  localparam logic [3:0] OP_R1SQ  = 4'd1;
  localparam logic [3:0] OP_SQ1   = 4'd2;
  localparam logic [3:0] OP_R2SQ  = 4'd3;
  localparam logic [3:0] OP_SQ2   = 4'd4;
  localparam logic [3:0] OP_TSQ   = 4'd5;
  localparam logic [3:0] OP_V1RR  = 4'd6;
  localparam logic [3:0] OP_V1RT  = 4'd7;
  localparam logic [3:0] OP_SG1   = 4'd8;
  localparam logic [3:0] OP_V2RR  = 4'd9;
  localparam logic [3:0] OP_SG2   = 4'd10;
  localparam logic [3:0] OP_VTT   = 4'd11;
  localparam logic [3:0] OP_VTR   = 4'd12;
  localparam logic [3:0] OP_SGT   = 4'd13;

  localparam logic [31:0] BEAR_HALF = 32'd1 << (31 - AW);

  // Configuration registers.
  logic [23:0]    a_rr_r, a_rt_r, a_tt_r, a_tr_r;
  logic [PW-1:0]  dx_r, dy_r;
  logic [AW-1:0]  prev_r, cur_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rr_r <= '0;
      a_rt_r <= '0;
      a_tt_r <= '0;
      a_tr_r <= '0;
      dx_r   <= '0;
      dy_r   <= '0;
      prev_r <= '0;
      cur_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA_RR:  a_rr_r <= cfg_data[23:0];
        REG_ALPHA_RT:  a_rt_r <= cfg_data[23:0];
        REG_ALPHA_TT:  a_tt_r <= cfg_data[23:0];
        REG_ALPHA_TR:  a_tr_r <= cfg_data[23:0];
        REG_DELTA_X:   dx_r   <= cfg_data;
        REG_DELTA_Y:   dy_r   <= cfg_data;
        REG_PREV_HEAD: prev_r <= cfg_data[AW-1:0];
        REG_CUR_HEAD:  cur_r  <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Serial unit for the terms that depend on the registers only.
  logic [2:0]            state_r;
  logic [3:0]            op_r;
  logic [5:0]            cnt_r;
  logic signed [XW-1:0]  x_r, y_r;
  logic [31:0]           z_r;
  logic [127:0]          ma_r, acc_r;
  logic [63:0]           mb_r;
  logic [63:0]           sqv_r, res_r, bit_r;
  logic [TW-1:0]         trans_r;
  logic [2*AW-1:0]       t_r;
  logic [63:0]           sq1_r, sq2_r, tsq_r, v_r, w_r, artq_r;
  logic [31:0]           sg1_r, sg2_r, sgt_r;

  logic [31:0]           bear_sum;
  logic [AW-1:0]         bearing, rot1, rot2, r1abs, r2abs;
  logic [63:0]           trans64, tclip, opa, opb, sqin;
  logic                  is_sqrt;
  logic [5:0]            run_last;
  logic signed [XW-1:0]  dxe, dye, ysh, xsh;
  logic [127:0]          rnd_trans, rnd_sq;
  logic [63:0]           sq_t;

  always_comb begin
    bear_sum = z_r + BEAR_HALF;
    bearing  = bear_sum[31:32-AW];
    trans64  = 64'(trans_r);
    rot1     = (trans64 < 64'(TRANS_GUARD_Q16)) ? '0 : bearing - prev_r;
    rot2     = cur_r - prev_r - rot1;
    r1abs    = rot1[AW-1] ? -rot1 : rot1;
    r2abs    = rot2[AW-1] ? -rot2 : rot2;
    tclip    = (trans64 > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : trans64;
    is_sqrt  = (op_r == OP_SG1) || (op_r == OP_SG2) || (op_r == OP_SGT);
    run_last = is_sqrt ? 6'd31 : 6'd63;
    dxe      = $signed({{2{dx_r[PW-1]}}, dx_r, 8'd0});
    dye      = $signed({{2{dy_r[PW-1]}}, dy_r, 8'd0});
    ysh      = y_r >>> cnt_r;
    xsh      = x_r >>> cnt_r;
    rnd_trans = acc_r + (128'd1 << 37);
    rnd_sq    = acc_r + (128'd1 << (SQS - 1));
    sq_t      = 64'(t_r);
    opa  = '0;
    opb  = '0;
    sqin = '0;
    case (op_r)
      OP_TRANS: begin opa = 64'(x_r);     opb = 64'(INVK_Q30);  end
      OP_R1SQ:  begin opa = 64'(r1abs);   opb = 64'(r1abs);     end
      OP_SQ1:   begin opa = sq_t;         opb = 64'(PI_SQ_Q14); end
      OP_R2SQ:  begin opa = 64'(r2abs);   opb = 64'(r2abs);     end
      OP_SQ2:   begin opa = sq_t;         opb = 64'(PI_SQ_Q14); end
      OP_TSQ:   begin opa = tclip;        opb = tclip;          end
      OP_V1RR:  begin opa = 64'(a_rr_r);  opb = sq1_r;          end
      OP_V1RT:  begin opa = 64'(a_rt_r);  opb = tsq_r;          end
      OP_SG1:   sqin = sat_add64(v_r, artq_r);
      OP_V2RR:  begin opa = 64'(a_rr_r);  opb = sq2_r;          end
      OP_SG2:   sqin = sat_add64(v_r, artq_r);
      OP_VTT:   begin opa = 64'(a_tt_r);  opb = tsq_r;          end
      OP_VTR:   begin opa = 64'(a_tr_r);  opb = sat_add64(sq1_r, sq2_r); end
      OP_SGT:   sqin = sat_add64(v_r, w_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CINIT;
      op_r    <= OP_TRANS;
      cnt_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      state_r <= ST_CINIT;
    end else begin
      case (state_r)
        ST_CINIT: begin
          cnt_r   <= '0;
          state_r <= ST_CROT;
        end
        ST_CROT: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(NS - 1)) begin
            op_r    <= OP_TRANS;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == run_last) state_r <= ST_STORE;
        end
        ST_STORE: begin
          if (op_r == OP_SGT) begin
            state_r <= ST_IDLE;
          end else begin
            op_r    <= op_r + 4'd1;
            state_r <= ST_LOAD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_CINIT: begin
        if (dxe < 0) begin
          x_r <= -dxe;
          y_r <= -dye;
          z_r <= 32'h8000_0000;
        end else begin
          x_r <= dxe;
          y_r <= dye;
          z_r <= '0;
        end
      end
      ST_CROT: begin
        if (y_r >= 0) begin
          x_r <= x_r + ysh;
          y_r <= y_r - xsh;
          z_r <= z_r + atan_entry(cnt_r[4:0]);
        end else begin
          x_r <= x_r - ysh;
          y_r <= y_r + xsh;
          z_r <= z_r - atan_entry(cnt_r[4:0]);
        end
      end
      ST_LOAD: begin
        ma_r  <= 128'(opa);
        mb_r  <= opb;
        acc_r <= '0;
        sqv_r <= sqin;
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      ST_RUN: begin
        if (mb_r[0]) acc_r <= acc_r + ma_r;
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
        if (sqv_r >= res_r + bit_r) begin
          sqv_r <= sqv_r - (res_r + bit_r);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_STORE: begin
        case (op_r)
          OP_TRANS: trans_r <= rnd_trans[38+TW-1:38];
          OP_R1SQ:  t_r     <= acc_r[2*AW-1:0];
          OP_SQ1:   sq1_r   <= rnd_sq[SQS+63:SQS];
          OP_R2SQ:  t_r     <= acc_r[2*AW-1:0];
          OP_SQ2:   sq2_r   <= rnd_sq[SQS+63:SQS];
          OP_TSQ:   tsq_r   <= acc_r[63:0];
          OP_V1RR:  v_r     <= alpha_sat(acc_r);
          OP_V1RT:  artq_r  <= alpha_sat(acc_r);
          OP_SG1:   sg1_r   <= res_r[31:0];
          OP_V2RR:  v_r     <= alpha_sat(acc_r);
          OP_SG2:   sg2_r   <= res_r[31:0];
          OP_VTT:   v_r     <= alpha_sat(acc_r);
          OP_VTR:   w_r     <= alpha_sat(acc_r);
          OP_SGT:   sgt_r   <= res_r[31:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Per-particle pipeline.
  logic en;
  logic skid_v_r, out_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en && (state_r == ST_IDLE);

  logic [PW-1:0]        in_px, in_py;
  logic [AW-1:0]        in_ph;
  logic signed [15:0]   in_n1, in_nt, in_n2;
  logic signed [48:0]   p1_nxt, p2_nxt, pt_nxt;

  always_comb begin
    in_px  = in_tdata[PW-1:0];
    in_py  = in_tdata[2*PW-1:PW];
    in_ph  = in_tdata[2*PW+AW-1:2*PW];
    in_n1  = $signed(in_tdata[2*PW+AW+15:2*PW+AW]);
    in_nt  = $signed(in_tdata[2*PW+AW+31:2*PW+AW+16]);
    in_n2  = $signed(in_tdata[2*PW+AW+47:2*PW+AW+32]);
    p1_nxt = $signed({1'b0, sg1_r}) * in_n1;
    p2_nxt = $signed({1'b0, sg2_r}) * in_n2;
    pt_nxt = $signed({1'b0, sgt_r}) * in_nt;
  end

  // Stage 1: sigma times noise.
  logic                v1_r;
  logic signed [48:0]  p1_r, p2_r, pt_r;
  logic [PW-1:0]       px1_r, py1_r;
  logic [AW-1:0]       ph1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      pt_r  <= pt_nxt;
      px1_r <= in_px;
      py1_r <= in_py;
      ph1_r <= in_ph;
    end
  end

  // Stage 2: magnitudes and translation noise rounding.
  logic         v2_r, s1_2_r, s2_2_r, st_2_r;
  logic [47:0]  m1_r, m2_r;
  logic [36:0]  mt_r;
  logic [PW-1:0] px2_r, py2_r;
  logic [AW-1:0] ph2_r;
  logic [48:0]  m1_nxt, m2_nxt, mtabs;
  logic [48:0]  mt_sum;

  always_comb begin
    m1_nxt = p1_r[48] ? -p1_r : p1_r;
    m2_nxt = p2_r[48] ? -p2_r : p2_r;
    mtabs  = pt_r[48] ? -pt_r : pt_r;
    mt_sum = {1'b0, mtabs[47:0]} + 49'd2048;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_nxt[47:0];
      m2_r   <= m2_nxt[47:0];
      s1_2_r <= p1_r[48];
      s2_2_r <= p2_r[48];
      mt_r   <= mt_sum[48:12];
      st_2_r <= pt_r[48];
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      ph2_r  <= ph1_r;
    end
  end

  // Stage 3: scale rotation noise by 1/pi, apply translation noise.
  logic          v3_r, s1_3_r, s2_3_r;
  logic [54:0]   q1l_r, q1h_r, q2l_r, q2h_r;
  logic [TRW-1:0] tr_r;
  logic [PW-1:0] px3_r, py3_r;
  logic [AW-1:0] ph3_r;
  logic [TRW-1:0] tn_ext;

  assign tn_ext = st_2_r ? -TRW'(mt_r) : TRW'(mt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1l_r  <= m1_r[23:0] * INV_PI_Q32;
      q1h_r  <= m1_r[47:24] * INV_PI_Q32;
      q2l_r  <= m2_r[23:0] * INV_PI_Q32;
      q2h_r  <= m2_r[47:24] * INV_PI_Q32;
      s1_3_r <= s1_2_r;
      s2_3_r <= s2_2_r;
      tr_r   <= TRW'(trans_r) - tn_ext;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      ph3_r  <= ph2_r;
    end
  end

  // Stage 4: round rotation noise, split translation into sign and magnitude.
  logic          v4_r, tneg4_r;
  logic [AW-1:0] rn1_r, rn2_r, ph4_r;
  logic [TMW-1:0] tm4_r;
  logic [PW-1:0] px4_r, py4_r;
  logic [79:0]   sum1, sum2;
  logic [AW-1:0] u1, u2;
  logic [TRW-1:0] trabs;

  always_comb begin
    sum1  = {1'b0, q1h_r, 24'd0} + 80'(q1l_r) + (80'd1 << (RS - 1));
    sum2  = {1'b0, q2h_r, 24'd0} + 80'(q2l_r) + (80'd1 << (RS - 1));
    u1    = sum1[RS+AW-1:RS];
    u2    = sum2[RS+AW-1:RS];
    trabs = tr_r[TRW-1] ? -tr_r : tr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn1_r   <= s1_3_r ? -u1 : u1;
      rn2_r   <= s2_3_r ? -u2 : u2;
      tneg4_r <= tr_r[TRW-1];
      tm4_r   <= trabs[TMW-1:0];
      px4_r   <= px3_r;
      py4_r   <= py3_r;
      ph4_r   <= ph3_r;
    end
  end

  // Stage 5: noisy rotations, travel direction and new heading.
  logic          v5_r, tneg5_r;
  logic [AW-1:0] phi_r, hd5_r;
  logic [TMW-1:0] tm5_r;
  logic [PW-1:0] px5_r, py5_r;
  logic [AW-1:0] r1n, r2n, phin;

  always_comb begin
    r1n  = rot1 - rn1_r;
    r2n  = rot2 - rn2_r;
    phin = ph4_r + r1n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r   <= phin;
      hd5_r   <= phin + r2n;
      tneg5_r <= tneg4_r;
      tm5_r   <= tm4_r;
      px5_r   <= px4_r;
      py5_r   <= py4_r;
    end
  end

  // Rotation CORDIC: quadrant fold, then one stage per iteration.
  logic signed [CW-1:0] cx_r [NS+1];
  logic signed [CW-1:0] cy_r [NS+1];
  logic signed [ZW-1:0] zr_r [NS+1];
  logic                 cv_r [NS+1];
  logic                 cflip_r [NS+1];
  logic                 ctn_r [NS+1];
  logic [TMW-1:0]       ctm_r [NS+1];
  logic [PW-1:0]        cpx_r [NS+1];
  logic [PW-1:0]        cpy_r [NS+1];
  logic [AW-1:0]        chd_r [NS+1];

  logic [31:0] phi32, phiq, zr32;

  always_comb begin
    phi32 = {phi_r, {(32 - AW){1'b0}}};
    phiq  = phi32 + 32'h4000_0000;
    zr32  = phiq[31] ? phi32 + 32'h8000_0000 : phi32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]    <= $signed(CW'(INVK_Q30));
      cy_r[0]    <= '0;
      zr_r[0]    <= ZW'($signed(zr32));
      cflip_r[0] <= phiq[31];
      ctn_r[0]   <= tneg5_r;
      ctm_r[0]   <= tm5_r;
      cpx_r[0]   <= px5_r;
      cpy_r[0]   <= py5_r;
      chd_r[0]   <= hd5_r;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] at;

    always_comb begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      at = $signed(ZW'(atan_entry(5'(i))));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (en) cv_r[i+1] <= cv_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (zr_r[i] >= 0) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          zr_r[i+1] <= zr_r[i] - at;
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          zr_r[i+1] <= zr_r[i] + at;
        end
        cflip_r[i+1] <= cflip_r[i];
        ctn_r[i+1]   <= ctn_r[i];
        ctm_r[i+1]   <= ctm_r[i];
        cpx_r[i+1]   <= cpx_r[i];
        cpy_r[i+1]   <= cpy_r[i];
        chd_r[i+1]   <= chd_r[i];
      end
    end
  end

  // M1: magnitudes and signs of cos and sin.
  logic          vm1_r, xn1_r, yn1_r;
  logic [31:0]   cm_r, sm_r;
  logic [TMW-1:0] tm6_r;
  logic [PW-1:0] px6_r, py6_r;
  logic [AW-1:0] hd6_r;
  logic [CW-1:0] cxa, cya;

  always_comb begin
    cxa = cx_r[NS][CW-1] ? -cx_r[NS] : cx_r[NS];
    cya = cy_r[NS][CW-1] ? -cy_r[NS] : cy_r[NS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vm1_r <= 1'b0;
    else if (en) vm1_r <= cv_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r  <= cxa[31:0];
      sm_r  <= cya[31:0];
      xn1_r <= cx_r[NS][CW-1] ^ cflip_r[NS] ^ ctn_r[NS];
      yn1_r <= cy_r[NS][CW-1] ^ cflip_r[NS] ^ ctn_r[NS];
      tm6_r <= ctm_r[NS];
      px6_r <= cpx_r[NS];
      py6_r <= cpy_r[NS];
      hd6_r <= chd_r[NS];
    end
  end

  // M2: partial products of travel times cos and sin.
  logic          vm2_r, xn2_r, yn2_r;
  logic [63:0]   pxl_r, pyl_r;
  logic [THW+31:0] pxh_r, pyh_r;
  logic [PW-1:0] px7_r, py7_r;
  logic [AW-1:0] hd7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm2_r <= 1'b0;
    else if (en) vm2_r <= vm1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r <= tm6_r[31:0] * cm_r;
      pyl_r <= tm6_r[31:0] * sm_r;
      pxh_r <= tm6_r[TMW-1:32] * cm_r;
      pyh_r <= tm6_r[TMW-1:32] * sm_r;
      xn2_r <= xn1_r;
      yn2_r <= yn1_r;
      px7_r <= px6_r;
      py7_r <= py6_r;
      hd7_r <= hd6_r;
    end
  end

  // M3: sum and round to Q.16.
  logic          vm3_r, xn3_r, yn3_r;
  logic [MW-1:0] mxu_r, myu_r;
  logic [PW-1:0] px8_r, py8_r;
  logic [AW-1:0] hd8_r;
  logic [TMW+32:0] sumx, sumy;

  always_comb begin
    sumx = {1'b0, pxh_r, 32'd0} + (TMW+33)'(pxl_r) + ((TMW+33)'(1) << 29);
    sumy = {1'b0, pyh_r, 32'd0} + (TMW+33)'(pyl_r) + ((TMW+33)'(1) << 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vm3_r <= 1'b0;
    else if (en) vm3_r <= vm2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxu_r <= sumx[TMW+32:30];
      myu_r <= sumy[TMW+32:30];
      xn3_r <= xn2_r;
      yn3_r <= yn2_r;
      px8_r <= px7_r;
      py8_r <= py7_r;
      hd8_r <= hd7_r;
    end
  end

  // M4: add to the pose and saturate.
  logic          vf_r;
  logic [PW-1:0] fx_r, fy_r;
  logic [AW-1:0] fh_r;
  logic [SW-1:0] pxe, pye, mxe, mye, sx, sy;
  logic [PW-1:0] satx, saty;
  localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW - 1){1'b1}}};
  localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW - 1){1'b0}}};

  always_comb begin
    pxe  = SW'($signed(px8_r));
    pye  = SW'($signed(py8_r));
    mxe  = SW'(mxu_r);
    mye  = SW'(myu_r);
    sx   = xn3_r ? pxe - mxe : pxe + mxe;
    sy   = yn3_r ? pye - mye : pye + mye;
    satx = sx[PW-1:0];
    saty = sy[PW-1:0];
    if (sx[SW-1:PW-1] != '0 && sx[SW-1:PW-1] != '1) satx = sx[SW-1] ? POS_MIN : POS_MAX;
    if (sy[SW-1:PW-1] != '0 && sy[SW-1:PW-1] != '1) saty = sy[SW-1] ? POS_MIN : POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (en) vf_r <= vm3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r <= satx;
      fy_r <= saty;
      fh_r <= hd8_r;
    end
  end

  // Output register with skid stage.
  logic [OUT_BITS-1:0] out_q_r, skid_q_r;
  logic                load_out;

  assign load_out = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (load_out) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (vf_r) begin
      if (load_out) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (load_out) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (load_out) out_q_r <= skid_q_r;
    end else if (vf_r) begin
      if (load_out) out_q_r <= {fh_r, fy_r, fx_r};
      else skid_q_r <= {fh_r, fy_r, fx_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_q_r);

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input accepted right after a register write");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while output register empty");

  a_final_lands: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r && en |=> out_v_r)
    else $error("finished beat dropped at the output");

endmodule
